@@ hdl/hpt_pkg.sv @@
// Package with types, constants and helpers for the homogeneous point transform.
`default_nettype none
package hpt_pkg;

  localparam int unsigned NumPairs  = 8;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned HW        = 50;
  localparam int unsigned QW        = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned QDepthDef = 4;

  localparam logic OP_COL = 1'b0;
  localparam logic OP_ROW = 1'b1;

  typedef struct packed {
    logic               op;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic signed [31:0] qz;
    logic               w_zero;
  } out_word_t;

  typedef logic [63:0] pair_t;
  typedef pair_t [NumPairs-1:0] mat_t;

  localparam mat_t MatReset = {
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd4294967296000
  };

  function automatic logic signed [31:0] elem(mat_t m, logic [1:0] r, logic [1:0] c);
    pair_t p;
    p = m[{r, c[1]}];
    return c[0] ? p[31:0] : p[63:32];
  endfunction

endpackage
`default_nettype wire

@@ hdl/hpt_fifo.sv @@
// Input queue between the accepting front and the arithmetic back end.
`default_nettype none
module hpt_fifo
  import hpt_pkg::*;
#(
  parameter int unsigned Depth = QDepthDef
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_word_t data_i,
  input  wire logic     pop_i,
  output      in_word_t head_o,
  output      logic     full_o,
  output      logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  in_word_t            mem_q [Depth];
  logic     [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic     [CntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ hdl/hpt_div.sv @@
// Pipelined radix-2 signed divider with Q16.16 saturation, one quotient bit per stage.
`default_nettype none
module hpt_div
  import hpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [HW-1:0] num_i,
  input  wire logic signed [HW-1:0] den_i,
  output      logic        [QW-1:0] q_o
);

  localparam int unsigned Steps = QW;

  logic [HW-1:0] n_abs, d_abs;
  logic          ovf;

  logic [HW-1:0] rem_q [Steps+1];
  logic [HW-1:0] den_q [Steps+1];
  logic [QW-1:0] nb_q  [Steps+1];
  logic [QW-1:0] qt_q  [Steps+1];
  logic          neg_q [Steps+1];
  logic          ovf_q [Steps+1];

  logic [HW-1:0] rem_n [Steps];
  logic [HW:0]   rem_s [Steps];
  logic          ge    [Steps];

  assign n_abs = num_i[HW-1] ? HW'(-num_i) : HW'(num_i);
  assign d_abs = den_i[HW-1] ? HW'(-den_i) : HW'(den_i);
  assign ovf   = {{FracW{1'b0}}, n_abs} >= {d_abs, {FracW{1'b0}}};

  always_comb begin
    for (int j = 0; j < Steps; j++) begin
      rem_s[j] = {rem_q[j], nb_q[j][QW-1]};
      ge[j]    = rem_s[j] >= {1'b0, den_q[j]};
      rem_n[j] = ge[j] ? HW'(rem_s[j] - {1'b0, den_q[j]}) : HW'(rem_s[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {{FracW{1'b0}}, n_abs[HW-1:FracW]};
      den_q[0] <= d_abs;
      nb_q[0]  <= {n_abs[FracW-1:0], {(QW-FracW){1'b0}}};
      qt_q[0]  <= '0;
      neg_q[0] <= num_i[HW-1] ^ den_i[HW-1];
      ovf_q[0] <= ovf;
      for (int j = 0; j < Steps; j++) begin
        rem_q[j+1] <= rem_n[j];
        den_q[j+1] <= den_q[j];
        nb_q[j+1]  <= {nb_q[j][QW-2:0], 1'b0};
        qt_q[j+1]  <= {qt_q[j][QW-2:0], ge[j]};
        neg_q[j+1] <= neg_q[j];
        ovf_q[j+1] <= ovf_q[j];
      end
    end
  end

  always_comb begin
    if (neg_q[Steps]) begin
      q_o = (ovf_q[Steps] || qt_q[Steps][QW-1]) ? {1'b1, {(QW-1){1'b0}}} : -qt_q[Steps];
    end else begin
      q_o = (ovf_q[Steps] || qt_q[Steps][QW-1]) ? {1'b0, {(QW-1){1'b1}}} : qt_q[Steps];
    end
  end

endmodule
`default_nettype wire

@@ hdl/hpt_mac.sv @@
// Matrix-times-point products and sums giving homogeneous x, y, z and w.
`default_nettype none
module hpt_mac
  import hpt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire mat_t                 mat_i,
  input  wire in_word_t             word_i,
  output      logic signed [HW-1:0] h_o [4]
);

  logic signed [31:0] p [3];
  logic signed [31:0] e [4][3];
  logic signed [31:0] t [4];
  logic signed [63:0] prod_q [4][3];
  logic signed [31:0] tr_q [4];
  logic signed [HW-1:0] h_q [4];
  logic signed [HW-1:0] h_d [4];

  assign p[0] = word_i.px;
  assign p[1] = word_i.py;
  assign p[2] = word_i.pz;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 3; k++) begin
        e[i][k] = (word_i.op == OP_ROW) ? elem(mat_i, 2'(k), 2'(i)) : elem(mat_i, 2'(i), 2'(k));
      end
      t[i] = (word_i.op == OP_ROW) ? elem(mat_i, 2'd3, 2'(i)) : elem(mat_i, 2'(i), 2'd3);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      h_d[i] = HW'(tr_q[i]);
      for (int k = 0; k < 3; k++) begin
        h_d[i] = h_d[i] + HW'($signed(prod_q[i][k][63:FracW]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          prod_q[i][k] <= e[i][k] * p[k];
        end
        tr_q[i] <= t[i];
        h_q[i]  <= h_d[i];
      end
    end
  end

  assign h_o = h_q;

endmodule
`default_nettype wire

@@ hdl/homogeneous_point_transform_core.sv @@
// Top level of the homogeneous point transform with perspective divide.
// Usage:
//   Input words (op, px, py, pz) enter on in_valid_i/in_stall_o and go into
//   a short queue; results (qx, qy, qz, w_zero) leave on out_valid_o/out_stall_i.
//   Matrix pairs are written on the cfg channel (cfg_ready_o is always high);
//   write them only while no word is in flight. Indexes above 7 are dropped.
//   Throughput: one word per cycle while out_stall_i does not hold the back end,
//   set by the fully pipelined multipliers and the 32-stage divider that yields
//   one quotient bit per stage. An accepted word passes the queue and products,
//   the sums, the divider setup, the divider stages and the output register.
//   When the receiver stalls, the back end freezes and the queue fills; then
//   in_stall_o rises. Reset empties the pipeline and loads the identity-like
//   default matrix.
`default_nettype none
module homogeneous_point_transform_core
  import hpt_pkg::*;
#(
  parameter int unsigned QueueDepth = QDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire in_word_t           in_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      out_word_t          out_o,
  input  wire logic               cfg_valid_i,
  output      logic               cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]        cfg_data_i
);

  localparam int unsigned VLast = QW + 2;

  mat_t                 mat_q;
  in_word_t             head;
  logic                 full, empty, adv, pop;
  logic                 v_q [VLast+1];
  logic                 wz_q [2:VLast];
  logic signed [HW-1:0] h [4];
  logic [QW-1:0]        q [3];
  logic                 out_valid_q;
  out_word_t            out_q;

  assign cfg_ready_o = 1'b1;
  assign adv         = ~out_valid_q | ~out_stall_i;
  assign pop         = adv & ~empty;
  assign in_stall_o  = full;

  hpt_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(in_valid_i), .data_i(in_i), .pop_i(pop),
    .head_o(head), .full_o(full), .empty_o(empty)
  );

  hpt_mac u_mac (.clk_i, .en_i(adv), .mat_i(mat_q), .word_i(head), .h_o(h));

  for (genvar g = 0; g < 3; g++) begin : gen_div
    hpt_div u_div (.clk_i, .en_i(adv), .num_i(h[g]), .den_i(h[3]), .q_o(q[g]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= MatReset;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_idx_i < CfgIdxW'(NumPairs))) begin
      mat_q[cfg_idx_i[$clog2(NumPairs)-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= VLast; j++) begin
        v_q[j] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= ~empty;
      for (int j = 1; j <= VLast; j++) begin
        v_q[j] <= v_q[j-1];
      end
      out_valid_q <= v_q[VLast];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wz_q[2] <= (h[3] == '0);
      for (int j = 3; j <= VLast; j++) begin
        wz_q[j] <= wz_q[j-1];
      end
      out_q.qx     <= q[0];
      out_q.qy     <= q[1];
      out_q.qz     <= q[2];
      out_q.w_zero <= wz_q[VLast];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_wzero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.w_zero |->
      (out_o.qx == 32'sh7FFFFFFF || out_o.qx == 32'sh80000000))
    else $error("zero w without saturated x");
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (v_q[VLast] == $past(v_q[VLast])) && $stable(out_o))
    else $error("pipeline moved while stalled");
  a_deliver: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && v_q[VLast] |=> out_valid_o)
    else $error("result lost at output register");
`endif

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for the homogeneous point transform core: predicted words vs. DUT output.
`timescale 1ns / 100ps
module tb_top;
  import hpt_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [63:0] cfg_data = '0;

  homogeneous_point_transform_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_o(out_word),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pair_t matrix [NumPairs];
  out_word_t expected_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  function automatic longint mat_elem(int r, int c);
    pair_t p;
    p = matrix[r * 2 + c / 2];
    return (c % 2 == 0) ? longint'($signed(p[63:32])) : longint'($signed(p[31:0]));
  endfunction

  function automatic logic [31:0] fixed_divide(longint num, longint w);
    logic neg;
    logic [63:0] n, d, q;
    if (w == 0) return (num >= 0) ? 32'h7FFFFFFF : 32'h80000000;
    neg = (num < 0) != (w < 0);
    n = (num < 0) ? -num : num;
    d = (w < 0) ? -w : w;
    q = (n << 16) / d;
    if (neg) return (q >= 64'h80000000) ? 32'h80000000 : 32'(-q);
    return (q > 64'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
  endfunction

  function automatic out_word_t project_point(in_word_t w);
    longint pt [3];
    longint h [4];
    longint e;
    out_word_t r;
    pt[0] = w.px; pt[1] = w.py; pt[2] = w.pz;
    for (int i = 0; i < 4; i++) begin
      h[i] = 0;
      for (int k = 0; k < 3; k++) begin
        e = (w.op == OP_ROW) ? mat_elem(k, i) : mat_elem(i, k);
        h[i] += (e * pt[k]) >>> 16;
      end
      h[i] += (w.op == OP_ROW) ? mat_elem(3, i) : mat_elem(i, 3);
    end
    r.qx = fixed_divide(h[0], h[3]);
    r.qy = fixed_divide(h[1], h[3]);
    r.qz = fixed_divide(h[2], h[3]);
    r.w_zero = (h[3] == 0);
    return r;
  endfunction

  // Check results.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word %h", out_word);
        errors++;
      end else begin
        out_word_t x;
        x = expected_q.pop_front();
        if (out_word.qx !== x.qx) begin
          $error("qx exp %h got %h", x.qx, out_word.qx); errors++;
        end
        if (out_word.qy !== x.qy) begin
          $error("qy exp %h got %h", x.qy, out_word.qy); errors++;
        end
        if (out_word.qz !== x.qz) begin
          $error("qz exp %h got %h", x.qz, out_word.qz); errors++;
        end
        if (out_word.w_zero !== x.w_zero) begin
          $error("w_zero exp %b got %b", x.w_zero, out_word.w_zero); errors++;
        end
      end
    end
  end

  // Drive receiver stall.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_cycles > 0 || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(project_point(w));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_pair(int idx, pair_t val);
    cfg_valid <= 1'b1;
    cfg_idx <= idx[CfgIdxW-1:0];
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < NumPairs) matrix[idx] = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(8) << 16;
      3: return -($urandom_range(8) << 16);
      4: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t rand_point();
    in_word_t w;
    w.op = $urandom_range(1);
    w.px = rand_coord();
    w.py = rand_coord();
    w.pz = rand_coord();
    return w;
  endfunction

  function automatic pair_t rand_pair();
    logic [31:0] h [2];
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(4))
        0: h[i] = 0;
        1: h[i] = ($urandom_range(4) - 2) << 16;
        2: h[i] = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        default: h[i] = $urandom;
      endcase
    end
    return {h[0], h[1]};
  endfunction

  task automatic test_directed();
    in_word_t w;
    logic [31:0] vals [6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                              32'hFFFF0000, 32'hFFFFFFFF};
    for (int i = 0; i < 12; i++) begin
      w.op = 1'(i % 2);
      w.px = vals[i % 6];
      w.py = vals[(i + 2) % 6];
      w.pz = vals[(i + 4) % 6];
      send_word(w);
    end
    drain();
    // Zero w: zero matrix row/column for w.
    write_pair(6, '0);
    write_pair(7, '0);
    write_pair(1, 64'h00000000_00000000);
    w = '{OP_COL, 32'h00010000, 32'hFFFF0000, 32'h0};
    send_word(w);
    w.op = OP_ROW;
    send_word(w);
    w = '{OP_COL, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
    send_word(w);
    drain();
    write_pair(NumPairs + 3, '1);
    write_pair(NumPairs + 7, 64'h1234);
    write_pair(6, '0);
    write_pair(7, 64'h00000000_00010000);
    send_word('{OP_COL, 32'h00020000, 32'h00030000, 32'h00040000});
    drain();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_word(rand_point());
    drain();
  endtask

  task automatic test_matrices();
    for (int m = 0; m < 6; m++) begin
      for (int k = 0; k < NumPairs; k++) write_pair(k, rand_pair());
      // Keep w mostly sane so divides hit the middle range too.
      if (m % 2 == 0) begin
        write_pair(6, {32'h0, 32'h0});
        write_pair(7, {32'h0, 32'h00010000 + $urandom_range(65535)});
        matrix[6] = {32'h0, 32'h0};
      end
      test_random(110, (m % 3 == 1) ? 59 : 0, (m % 3 == 2) ? 59 : 0);
    end
    for (int k = 0; k < NumPairs; k++) write_pair(k, '1);
    test_random(40, 13, 13);
    for (int k = 0; k < NumPairs; k++) write_pair(k, {32'h7FFFFFFF, 32'h80000000});
    test_random(40, 0, 0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 100; i++) send_word(rand_point());
    drain();
  endtask

  initial begin
    for (int k = 0; k < NumPairs; k++) matrix[k] = MatReset[k];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 59, 0);
    test_random(200, 0, 59);
    test_random(150, 13, 13);
    test_backpressure();
    test_matrices();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
